@@ src/wbe_pkg.sv @@
// ----------------------------------------------------------------------------
// wbe_pkg
// Shared types and constants for the word-aligned hybrid bitmap encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wbe_pkg;

  localparam int WORD_BITS  = 32;
  localparam int GROUP_BITS = WORD_BITS - 1;
  localparam int LEN_BITS   = WORD_BITS - 2;

  // result queue depth, room for two items of two words each
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_GROUP = 1'b0,
    OP_END   = 1'b1
  } wbe_op_t;

  typedef struct packed {
    logic                  op;
    logic [GROUP_BITS-1:0] group_bits;
    logic                  partial;
  } wbe_in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] code_word;
    logic                 last;
  } wbe_out_t;

  typedef struct packed {
    logic                active;
    logic                value;
    logic [LEN_BITS-1:0] length;
  } wbe_run_t;

  typedef struct packed {
    logic [1:0] count;
    wbe_out_t   word0;
    wbe_out_t   word1;
  } wbe_step_t;

  function automatic logic [WORD_BITS-1:0] fill_word(input wbe_run_t run);
    fill_word = {1'b1, run.value, run.length};
  endfunction

endpackage

`default_nettype wire

@@ src/wbe_run_update.sv @@
// ----------------------------------------------------------------------------
// wbe_run_update
// Per-item run tracking: next run state and up to two code words.
// ----------------------------------------------------------------------------
`default_nettype none

module wbe_run_update (
  input  wbe_pkg::wbe_run_t  run,
  input  wbe_pkg::wbe_in_t   item,
  output wbe_pkg::wbe_run_t  run_next,
  output wbe_pkg::wbe_step_t step
);
  import wbe_pkg::*;

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

  logic                 uniform;
  logic                 fill_val;
  logic [WORD_BITS-1:0] fill;
  logic [WORD_BITS-1:0] literal;
  wbe_run_t             run_clear;
  wbe_run_t             run_start;

  assign uniform   = (item.group_bits == '0) || (&item.group_bits);
  assign fill_val  = item.group_bits[0];
  assign fill      = fill_word(run);
  assign literal   = {1'b0, item.group_bits};
  assign run_clear = '{active: 1'b0, value: 1'b0, length: '0};
  assign run_start = '{active: 1'b1, value: fill_val, length: LEN_ONE};

  always_comb begin
    run_next        = run;
    step.count      = 2'd0;
    step.word0      = '{code_word: fill, last: 1'b1};
    step.word1      = '{code_word: literal, last: 1'b1};
    if (item.op == OP_END) begin
      if (run.active) begin
        step.count = 2'd1;
        run_next   = run_clear;
      end
    end else if (!uniform || item.partial) begin
      // pending fill goes out ahead of the literal
      if (run.active) begin
        step.count      = 2'd2;
        step.word0.last = 1'b0;
        run_next        = run_clear;
      end else begin
        step.count = 2'd1;
        step.word0 = '{code_word: literal, last: 1'b1};
      end
    end else if (!run.active) begin
      run_next = run_start;
    end else if (fill_val != run.value) begin
      step.count = 2'd1;
      run_next   = run_start;
    end else if (run.length == LEN_MAX) begin
      // saturated run: flush and restart at one
      step.count = 2'd1;
      run_next   = run_start;
    end else begin
      run_next.length = run.length + LEN_ONE;
    end
  end

endmodule

`default_nettype wire

@@ src/wbe_out_queue.sv @@
// ----------------------------------------------------------------------------
// wbe_out_queue
// Small result queue taking up to two words per cycle, giving one per cycle while code_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module wbe_out_queue (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wbe_pkg::wbe_step_t                    push,
  input  logic                                  push_en,
  output logic [wbe_pkg::QCNT_BITS-1:0]         fill_level,
  output wbe_pkg::wbe_out_t                     code,
  output logic                                  code_valid,
  input  logic                                  code_ready
);
  import wbe_pkg::*;

  wbe_out_t               entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   wr_ptr_next;
  logic [QPTR_BITS-1:0]   wr_ptr_plus;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  logic [QCNT_BITS-1:0]   count_next;
  logic [1:0]             push_cnt;
  logic                   pop;

  assign push_cnt    = push_en ? push.count : 2'd0;
  assign pop         = code_valid && code_ready;
  assign wr_ptr_plus = wr_ptr + QPTR_BITS'(1);
  assign wr_ptr_next = wr_ptr + QPTR_BITS'(push_cnt);
  assign count_next  = count + QCNT_BITS'(push_cnt) - QCNT_BITS'(pop);

  assign code_valid  = (count != '0);
  assign code        = entries[rd_ptr];
  assign fill_level  = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entries[wr_ptr] <= push.word0;
    end
    if (push_cnt == 2'd2) begin
      entries[wr_ptr_plus] <= push.word1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |=> (count_next <= QCNT_BITS'(2)) || ($past(push_cnt) != 2'd0))
    else $error("result queue count moved without a push");

endmodule

`default_nettype wire

@@ src/wah_bitmap_word_encoder_core.sv @@
// ----------------------------------------------------------------------------
// wah_bitmap_word_encoder_core
// Word-aligned hybrid encoder: bitmap groups in, fill and literal words out.
// ----------------------------------------------------------------------------
// data path: an item is registered in grp_q, then its words are written to the
//   result queue, from which the first word can be taken
// throughput: 1 item per cycle while items give at most one word each and
//   code_ready stays high; a fill plus a literal leave in turn at the single-word output
// the 4-entry result queue sets how far the input runs ahead of a stall
// reset: synchronous, clears the pending run, drops the held item and empties the result queue
`default_nettype none

module wah_bitmap_word_encoder_core (
  input  logic              clk,
  input  logic              rst,
  input  wbe_pkg::wbe_in_t  grp,
  input  logic              grp_valid,
  output logic              grp_ready,
  output wbe_pkg::wbe_out_t code,
  output logic              code_valid,
  input  logic              code_ready
);
  import wbe_pkg::*;

  wbe_in_t                grp_q;
  logic                   grp_q_valid;
  wbe_run_t               run;
  wbe_run_t               run_next;
  wbe_step_t              step;
  logic [QCNT_BITS-1:0]   fill_level;
  logic                   advance;

  // queue must have room for two words before an item moves on
  assign advance   = grp_q_valid &&
                     (fill_level <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign grp_ready = !grp_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_q_valid <= 1'b0;
    end else if (grp_ready) begin
      grp_q_valid <= grp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_ready && grp_valid) begin
      grp_q <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '{active: 1'b0, value: 1'b0, length: '0};
    end else if (advance) begin
      run <= run_next;
    end
  end

  wbe_run_update u_run_update (
    .run      (run),
    .item     (grp_q),
    .run_next (run_next),
    .step     (step)
  );

  wbe_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_en    (advance),
    .fill_level (fill_level),
    .code       (code),
    .code_valid (code_valid),
    .code_ready (code_ready)
  );

  a_run_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    run.active |-> (run.length != '0))
    else $error("active run with zero length");

  a_idle_run_clear: assert property (@(posedge clk) disable iff (rst)
    !run.active |-> ((run.length == '0) && !run.value))
    else $error("idle run holds stale state");

  a_fill_then_more: assert property (@(posedge clk) disable iff (rst)
    (code_valid && !code.last) |-> (fill_level >= QCNT_BITS'(2)))
    else $error("non-final word without its follower queued");

  a_split_is_fill: assert property (@(posedge clk) disable iff (rst)
    (code_valid && !code.last) |-> code.code_word[WORD_BITS-1])
    else $error("non-final word is not a fill");

endmodule

`default_nettype wire
